/* hdl/mqtj_pkg.sv */
// Shared types and constants for the multi-queue tuple join.
`timescale 1ns / 1ps
`default_nettype none

package mqtj_pkg;

   localparam int PORT_W          = 3;
   localparam int DATA_W          = 32;
   localparam int CNT_W           = 4;
   localparam int CFG_RESET_COUNT = 2;

   localparam int MAX_PORTS_DEF   = 8;
   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int WORD_WIDTH_DEF  = 32;

   localparam int CMDQ_DEPTH = 4;
   localparam int OUTQ_DEPTH = 4;

   // Command from front to back: either a rejected word or a tuple to drain.
   typedef struct packed {
      logic              drop;
      logic [PORT_W-1:0] port;
      logic [DATA_W-1:0] word;
      logic [CNT_W-1:0]  count;
   } cmd_type;

   // Back tells front that a queue slot has been read and may be reused.
   typedef struct packed {
      logic              valid;
      logic [PORT_W-1:0] port;
   } release_type;

endpackage

`default_nettype wire

/* hdl/mqtj_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module mqtj_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/mqtj_cmdq.sv */
// Short command queue between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module mqtj_cmdq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  mqtj_pkg::cmd_type     push_data,
   output      logic             full,
   input  wire logic             pop,
   output mqtj_pkg::cmd_type     pop_data,
   output      logic             empty
);
   import mqtj_pkg::*;

   localparam int PTR_W = $clog2(CMDQ_DEPTH);
   localparam int CNT_QW = $clog2(CMDQ_DEPTH + 1);

   cmd_type           q_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_QW-1:0] cnt_ff, cnt_in;
   logic              do_push, do_pop;

   always_comb begin
      do_push   = push && !full;
      do_pop    = pop && !empty;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + CNT_QW'(do_push) - CNT_QW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full     = (cnt_ff == CNT_QW'(CMDQ_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* hdl/mqtj_front.sv */
// Front: takes words, keeps per-port tail and fill state, decides drops and tuples.
`timescale 1ns / 1ps
`default_nettype none

module mqtj_front #(
   parameter int MAX_PORTS   = mqtj_pkg::MAX_PORTS_DEF,
   parameter int QUEUE_DEPTH = mqtj_pkg::QUEUE_DEPTH_DEF,
   parameter int WORD_WIDTH  = mqtj_pkg::WORD_WIDTH_DEF,
   localparam int PIDX_W  = $clog2(MAX_PORTS),
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH),
   localparam int ADDR_W  = PIDX_W + SLOT_W,
   localparam int STORE_W = (WORD_WIDTH < mqtj_pkg::DATA_W) ? WORD_WIDTH : mqtj_pkg::DATA_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output      logic                          req_full,
   input  wire logic [mqtj_pkg::PORT_W-1:0]   req_port_index,
   input  wire logic [mqtj_pkg::DATA_W-1:0]   req_payload,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [mqtj_pkg::CNT_W-1:0]    csr_data,
   output      logic                          ram_wr_en,
   output      logic [ADDR_W-1:0]             ram_wr_addr,
   output      logic [STORE_W-1:0]            ram_wr_data,
   output      logic                          cmd_push,
   output mqtj_pkg::cmd_type                  cmd_data,
   input  wire logic                          cmdq_full,
   input  mqtj_pkg::release_type              release_info
);
   import mqtj_pkg::*;

   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]  port_count_ff, port_count_in;
   logic [FILL_W-1:0] fill_ff [MAX_PORTS];
   logic [FILL_W-1:0] fill_in [MAX_PORTS];
   logic [FILL_W-1:0] phys_ff [MAX_PORTS];
   logic [FILL_W-1:0] phys_in [MAX_PORTS];
   logic [SLOT_W-1:0] tail_ff [MAX_PORTS];
   logic [SLOT_W-1:0] tail_in [MAX_PORTS];

   logic [CNT_W-1:0]  eff_count;
   logic [PIDX_W-1:0] pi;
   logic              in_range, is_drop, accept, append, all_ok, tuple, hold;

   always_comb begin
      port_count_in = (csr_valid && csr_ready) ? csr_data : port_count_ff;

      if (port_count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (port_count_ff > CNT_W'(MAX_PORTS)) begin
         eff_count = CNT_W'(MAX_PORTS);
      end else begin
         eff_count = port_count_ff;
      end

      pi       = req_port_index[PIDX_W-1:0];
      in_range = CNT_W'(req_port_index) < eff_count;
      is_drop  = !in_range || (fill_ff[pi] == FILL_W'(QUEUE_DEPTH));

      // a slot still waiting for its read must not be overwritten
      hold = 1'b0;
      for (int i = 0; i < MAX_PORTS; i++) begin
         if (phys_ff[i] == FILL_W'(QUEUE_DEPTH) && fill_ff[i] != FILL_W'(QUEUE_DEPTH)) begin
            hold = 1'b1;
         end
      end

      accept = req_push && !req_full;
      append = accept && !is_drop;

      all_ok = 1'b1;
      for (int i = 0; i < MAX_PORTS; i++) begin
         if (CNT_W'(i) < eff_count && fill_ff[i] == '0 &&
             !(in_range && pi == PIDX_W'(i))) begin
            all_ok = 1'b0;
         end
      end
      tuple = append && all_ok;

      for (int i = 0; i < MAX_PORTS; i++) begin
         fill_in[i] = fill_ff[i]
                    + FILL_W'(append && pi == PIDX_W'(i))
                    - FILL_W'(tuple && CNT_W'(i) < eff_count);
         phys_in[i] = phys_ff[i]
                    + FILL_W'(append && pi == PIDX_W'(i))
                    - FILL_W'(release_info.valid
                              && release_info.port[PIDX_W-1:0] == PIDX_W'(i));
         tail_in[i] = tail_ff[i];
         if (append && pi == PIDX_W'(i)) begin
            tail_in[i] = (tail_ff[i] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff <= CNT_W'(CFG_RESET_COUNT);
         for (int i = 0; i < MAX_PORTS; i++) begin
            fill_ff[i] <= '0;
            phys_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         port_count_ff <= port_count_in;
         for (int i = 0; i < MAX_PORTS; i++) begin
            fill_ff[i] <= fill_in[i];
            phys_ff[i] <= phys_in[i];
            tail_ff[i] <= tail_in[i];
         end
      end
   end

   assign req_full   = cmdq_full || hold;
   assign csr_ready  = 1'b1;

   assign ram_wr_en   = append;
   assign ram_wr_addr = {pi, tail_ff[pi]};
   assign ram_wr_data = req_payload[STORE_W-1:0];

   assign cmd_push       = accept && (is_drop || tuple);
   assign cmd_data.drop  = is_drop;
   assign cmd_data.port  = req_port_index;
   assign cmd_data.word  = DATA_W'(req_payload[STORE_W-1:0]);
   assign cmd_data.count = eff_count;

   a_no_push_when_cmdq_full: assert property (@(posedge clock) disable iff (reset)
      !(cmd_push && cmdq_full))
      else $error("command pushed into full queue");

   a_append_has_room: assert property (@(posedge clock) disable iff (reset)
      append |-> (phys_ff[pi] < FILL_W'(QUEUE_DEPTH)))
      else $error("append would overwrite an unread slot");

   a_tuple_is_queued: assert property (@(posedge clock) disable iff (reset)
      tuple |-> (cmd_push && !cmd_data.drop))
      else $error("ready tuple not issued to back");

endmodule

`default_nettype wire

/* hdl/mqtj_back.sv */
// Back: drains commands, reads queued words from RAM and feeds the result queue.
`timescale 1ns / 1ps
`default_nettype none

module mqtj_back #(
   parameter int MAX_PORTS   = mqtj_pkg::MAX_PORTS_DEF,
   parameter int QUEUE_DEPTH = mqtj_pkg::QUEUE_DEPTH_DEF,
   parameter int WORD_WIDTH  = mqtj_pkg::WORD_WIDTH_DEF,
   localparam int PIDX_W  = $clog2(MAX_PORTS),
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH),
   localparam int ADDR_W  = PIDX_W + SLOT_W,
   localparam int STORE_W = (WORD_WIDTH < mqtj_pkg::DATA_W) ? WORD_WIDTH : mqtj_pkg::DATA_W
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  mqtj_pkg::cmd_type                  cmd_data,
   input  wire logic                          cmd_empty,
   output      logic                          cmd_pop,
   output      logic                          ram_rd_en,
   output      logic [ADDR_W-1:0]             ram_rd_addr,
   input  wire logic [STORE_W-1:0]            ram_rd_data,
   output mqtj_pkg::release_type              release_info,
   output      logic                          rsp_empty,
   input  wire logic                          rsp_pop,
   output      logic [mqtj_pkg::PORT_W-1:0]   rsp_source_port,
   output      logic [mqtj_pkg::DATA_W-1:0]   rsp_data_word,
   output      logic                          rsp_last_of_tuple,
   output      logic                          rsp_dropped
);
   import mqtj_pkg::*;

   localparam int OQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef enum logic [1:0] {
      BK_IDLE  = 2'b01,
      BK_TUPLE = 2'b10
   } back_state_type;

   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [DATA_W-1:0] word;
      logic              last;
      logic              dropped;
   } out_type;

   back_state_type    st_ff, st_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] rd_ptr_ff [MAX_PORTS];
   logic [SLOT_W-1:0] rd_ptr_in [MAX_PORTS];

   logic              pend_v_ff, pend_v_in;
   logic [PORT_W-1:0] pend_port_ff, pend_port_in;
   logic              pend_last_ff, pend_last_in;
   logic              pend_drop_ff, pend_drop_in;
   logic [DATA_W-1:0] pend_word_ff, pend_word_in;

   out_type             oq_ff [OUTQ_DEPTH];
   logic [OQ_PTR_W-1:0] oq_wr_ff, oq_wr_in;
   logic [OQ_PTR_W-1:0] oq_rd_ff, oq_rd_in;
   logic [OQ_CNT_W-1:0] oq_cnt_ff, oq_cnt_in;

   logic              credit, issue_rd, issue_drop, issue_last, out_pop;
   logic [PORT_W-1:0] issue_port;
   out_type           landing;

   always_comb begin
      credit     = (OQ_CNT_W'(oq_cnt_ff) + OQ_CNT_W'(pend_v_ff)) < OQ_CNT_W'(OUTQ_DEPTH);
      cmd_pop    = 1'b0;
      issue_rd   = 1'b0;
      issue_drop = 1'b0;
      issue_last = 1'b0;
      issue_port = '0;
      st_in      = st_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;

      unique case (st_ff)
         BK_IDLE: begin
            if (!cmd_empty && credit) begin
               cmd_pop    = 1'b1;
               issue_port = cmd_data.port;
               if (cmd_data.drop) begin
                  issue_drop = 1'b1;
               end else begin
                  issue_rd   = 1'b1;
                  issue_port = '0;
                  issue_last = (cmd_data.count == CNT_W'(1));
                  if (!issue_last) begin
                     st_in  = BK_TUPLE;
                     idx_in = CNT_W'(1);
                     cnt_in = cmd_data.count;
                  end
               end
            end
         end
         BK_TUPLE: begin
            if (credit) begin
               issue_rd   = 1'b1;
               issue_port = idx_ff[PORT_W-1:0];
               issue_last = (idx_ff == cnt_ff - 1'b1);
               idx_in     = idx_ff + 1'b1;
               if (issue_last) begin
                  st_in = BK_IDLE;
               end
            end
         end
         default: begin
            st_in = BK_IDLE;
         end
      endcase

      for (int i = 0; i < MAX_PORTS; i++) begin
         rd_ptr_in[i] = rd_ptr_ff[i];
         if (issue_rd && issue_port[PIDX_W-1:0] == PIDX_W'(i)) begin
            rd_ptr_in[i] = (rd_ptr_ff[i] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff[i] + 1'b1;
         end
      end

      pend_v_in    = issue_rd || issue_drop;
      pend_port_in = issue_port;
      pend_last_in = issue_last;
      pend_drop_in = issue_drop;
      pend_word_in = cmd_data.word;

      landing.port    = pend_port_ff;
      landing.word    = pend_drop_ff ? pend_word_ff : DATA_W'(ram_rd_data);
      landing.last    = pend_last_ff;
      landing.dropped = pend_drop_ff;

      out_pop   = rsp_pop && !rsp_empty;
      oq_wr_in  = pend_v_ff ? oq_wr_ff + 1'b1 : oq_wr_ff;
      oq_rd_in  = out_pop ? oq_rd_ff + 1'b1 : oq_rd_ff;
      oq_cnt_in = oq_cnt_ff + OQ_CNT_W'(pend_v_ff) - OQ_CNT_W'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= BK_IDLE;
         idx_ff    <= '0;
         cnt_ff    <= '0;
         pend_v_ff <= 1'b0;
         oq_wr_ff  <= '0;
         oq_rd_ff  <= '0;
         oq_cnt_ff <= '0;
         for (int i = 0; i < MAX_PORTS; i++) begin
            rd_ptr_ff[i] <= '0;
         end
      end else begin
         st_ff     <= st_in;
         idx_ff    <= idx_in;
         cnt_ff    <= cnt_in;
         pend_v_ff <= pend_v_in;
         oq_wr_ff  <= oq_wr_in;
         oq_rd_ff  <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
         for (int i = 0; i < MAX_PORTS; i++) begin
            rd_ptr_ff[i] <= rd_ptr_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_port_ff <= pend_port_in;
      pend_last_ff <= pend_last_in;
      pend_drop_ff <= pend_drop_in;
      pend_word_ff <= pend_word_in;
      if (pend_v_ff) begin
         oq_ff[oq_wr_ff] <= landing;
      end
   end

   assign ram_rd_en          = issue_rd;
   assign ram_rd_addr        = {issue_port[PIDX_W-1:0], rd_ptr_ff[issue_port[PIDX_W-1:0]]};
   assign release_info.valid = issue_rd;
   assign release_info.port  = issue_port;

   assign rsp_empty         = (oq_cnt_ff == '0);
   assign rsp_source_port   = oq_ff[oq_rd_ff].port;
   assign rsp_data_word     = oq_ff[oq_rd_ff].word;
   assign rsp_last_of_tuple = oq_ff[oq_rd_ff].last;
   assign rsp_dropped       = oq_ff[oq_rd_ff].dropped;

   a_outq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (OQ_CNT_W'(oq_cnt_ff) + OQ_CNT_W'(pend_v_ff)) <= OQ_CNT_W'(OUTQ_DEPTH))
      else $error("result queue overcommitted");

   a_drop_not_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_dropped && rsp_last_of_tuple))
      else $error("dropped word marked as tuple end");

   a_long_tuple_continues: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && !cmd_data.drop && cmd_data.count != CNT_W'(1)) |=> (st_ff == BK_TUPLE))
      else $error("multi-word tuple did not enter drain state");

   a_pend_follows_issue: assert property (@(posedge clock) disable iff (reset)
      (issue_rd || issue_drop) |=> pend_v_ff)
      else $error("issued word lost before result queue");

endmodule

`default_nettype wire

/* hdl/multi_queue_tuple_join.sv */
// Top level of the multi-queue tuple join: front, command queue, word RAM and back.
//
//   channel   ports                                     handshake
//   input     req_port_index, req_payload               req_push / req_full
//   result    rsp_source_port, rsp_data_word,           rsp_pop / rsp_empty
//             rsp_last_of_tuple, rsp_dropped
//   config    csr_data (port count)                     csr_valid / csr_ready
//
// The front takes one word per cycle while req_full is low; the back gives one result
// per cycle while the result queue has room; the single RAM read port sets that pace.
// With everything idle, the word that causes the first result passes the command queue,
// the RAM read and pending registers, then the result queue, before it shows.
// req_full rises when the command queue is full or a port with all slots taken still
// has slots waiting for a read.
// Synchronous reset clears pointers, counts and queues and sets the port count to 2;
// the word RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_queue_tuple_join #(
   parameter int MAX_PORTS   = mqtj_pkg::MAX_PORTS_DEF,
   parameter int QUEUE_DEPTH = mqtj_pkg::QUEUE_DEPTH_DEF,
   parameter int WORD_WIDTH  = mqtj_pkg::WORD_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output      logic                          req_full,
   input  wire logic [mqtj_pkg::PORT_W-1:0]   req_port_index,
   input  wire logic [mqtj_pkg::DATA_W-1:0]   req_payload,
   output      logic                          rsp_empty,
   input  wire logic                          rsp_pop,
   output      logic [mqtj_pkg::PORT_W-1:0]   rsp_source_port,
   output      logic [mqtj_pkg::DATA_W-1:0]   rsp_data_word,
   output      logic                          rsp_last_of_tuple,
   output      logic                          rsp_dropped,
   input  wire logic                          csr_valid,
   output      logic                          csr_ready,
   input  wire logic [mqtj_pkg::CNT_W-1:0]    csr_data
);
   import mqtj_pkg::*;

   localparam int PIDX_W  = $clog2(MAX_PORTS);
   localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
   localparam int ADDR_W  = PIDX_W + SLOT_W;
   localparam int STORE_W = (WORD_WIDTH < DATA_W) ? WORD_WIDTH : DATA_W;
   localparam int RAM_DEPTH = MAX_PORTS << SLOT_W;

   logic               ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
   logic [STORE_W-1:0] ram_wr_data, ram_rd_data;
   logic               cmd_push, cmdq_full, cmd_pop, cmd_empty;
   cmd_type            cmd_in, cmd_out;
   release_type        release_info;

   mqtj_front #(
      .MAX_PORTS   (MAX_PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_port_index (req_port_index),
      .req_payload    (req_payload),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_in),
      .cmdq_full      (cmdq_full),
      .release_info   (release_info)
   );

   mqtj_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmdq_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out),
      .empty     (cmd_empty)
   );

   mqtj_ram #(
      .WIDTH (STORE_W),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   mqtj_back #(
      .MAX_PORTS   (MAX_PORTS),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .WORD_WIDTH  (WORD_WIDTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_data          (cmd_out),
      .cmd_empty         (cmd_empty),
      .cmd_pop           (cmd_pop),
      .ram_rd_en         (ram_rd_en),
      .ram_rd_addr       (ram_rd_addr),
      .ram_rd_data       (ram_rd_data),
      .release_info      (release_info),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_source_port   (rsp_source_port),
      .rsp_data_word     (rsp_data_word),
      .rsp_last_of_tuple (rsp_last_of_tuple),
      .rsp_dropped       (rsp_dropped)
   );

endmodule

`default_nettype wire
